>>> sv/hbrmf_pkg.sv
// Package for the heightmap box/ramp max-fill block: grid constants,
// request codes, item structs and the controller state type.
// No dependencies.
package hbrmf_pkg;

  // Grid geometry
  localparam int GRID_HALF  = 64;
  localparam int GRID_SIDE  = 2 * GRID_HALF + 1;
  localparam int GRID_CELLS = GRID_SIDE * GRID_SIDE;
  localparam int IDX_W      = $clog2(GRID_SIDE);
  localparam int ADDR_W     = $clog2(GRID_CELLS);
  // Coordinate width: holds field coordinates, grid bounds and differences
  localparam int CW         = $clog2(GRID_HALF + 256) + 2;

  // Fixed-point widths
  localparam int HW = 24;  // height, Q15.8
  localparam int SW = 32;  // slope, Q15.16
  localparam int PW = SW + CW;  // slope times coordinate offset

  // Request codes
  localparam logic [1:0] REQ_BOX   = 2'd0;
  localparam logic [1:0] REQ_RAMP  = 2'd1;
  localparam logic [1:0] REQ_READ  = 2'd2;
  localparam logic [1:0] REQ_CLEAR = 2'd3;

  // Ramp rotations
  localparam logic [1:0] ROT_0   = 2'd0;
  localparam logic [1:0] ROT_90  = 2'd1;
  localparam logic [1:0] ROT_180 = 2'd2;
  localparam logic [1:0] ROT_270 = 2'd3;

  typedef struct packed {
    logic [1:0]           req_type;
    logic signed [7:0]    min_x;
    logic signed [7:0]    min_z;
    logic signed [7:0]    max_x;
    logic signed [7:0]    max_z;
    logic signed [HW-1:0] low_y;
    logic signed [HW-1:0] high_y;
    logic [1:0]           rotation;
  } in_t;

  typedef struct packed {
    logic signed [SW-1:0] slope;
    logic signed [HW-1:0] cell_height;
    logic                 status;
  } out_t;

  typedef enum logic [3:0] {
    ST_CLR,
    ST_IDLE,
    ST_DIV,
    ST_DFIN,
    ST_WALK,
    ST_DRAIN,
    ST_RD1,
    ST_RD2,
    ST_RESP
  } state_e;

endpackage

>>> sv/heightmap_box_ramp_max_fill.sv
// Per item: a box walks every cell of its clipped box; a ramp runs a bit-serial divide and then
// walks its clipped cells; a read does one memory read; a clear writes the floor to every cell.
// Throughput: one item at a time; the cell walk does one read-modify-write per cycle
// through the single-port-read height memory, so cost scales with box area.
// Reset: a sweep writes 0 to every cell; no item is taken until it ends.
// Configuration writes are accepted in every cycle.
module heightmap_box_ramp_max_fill
  import hbrmf_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  in_t                  in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output out_t                 out_data_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic signed [HW-1:0] cfg_data_i
);

  // Height memory
  logic signed [HW-1:0] height_mem [GRID_CELLS];

  state_e state_q, state_d;
  logic [ADDR_W-1:0] clr_q, clr_d;
  logic signed [HW-1:0] fill_q, fill_d;
  logic signed [HW-1:0] floor_q;
  logic clr_resp_q, clr_resp_d;

  logic [1:0] req_q, req_d;
  logic signed [HW-1:0] lo_q, lo_d, hi_q, hi_d;
  logic signed [CW-1:0] xs_q, xs_d, xe_q, xe_d, zs_q, zs_d, ze_q, ze_d;
  logic signed [CW-1:0] x_q, x_d, z_q, z_d, anchor_q, anchor_d;
  logic along_z_q, along_z_d;
  logic signed [SW-1:0] slope_q, slope_d;

  // Divider
  logic [31:0] num_q, num_d;
  logic [7:0]  den_q, den_d;
  logic [8:0]  rem_q, rem_d;
  logic [4:0]  cnt_q, cnt_d;
  logic        neg_q, neg_d;

  // Walk pipeline
  logic v0_q, v0_d, v1_q;
  logic signed [PW-1:0] prod_q, prod_d;
  logic [ADDR_W-1:0] addr0_q, addr0_d, addr1_q;
  logic signed [HW-1:0] tgt_q, tgt_d, rdata_q;

  out_t res_q, res_d;
  out_t out_q;
  logic out_valid_q;
  logic load_out;

  // Memory write port
  logic mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic signed [HW-1:0] mem_wdata;

  // Request decode helpers
  logic signed [CW-1:0] mnx, mnz, mxx, mxz, ex, ez, gh_p, gh_n;
  logic signed [CW-1:0] bxs, bxe, bzs, bze;
  logic signed [8:0] span;
  logic [8:0] span_abs;
  logic signed [HW:0] dy;
  logic [HW:0] dy_abs;
  logic [IDX_W-1:0] ix, iz;
  logic [CW-1:0] ixw, izw;
  logic signed [CW-1:0] dt;
  logic [8:0] rtry;
  logic rge;
  logic [SW:0] qmag;
  logic signed [SW+1:0] qsig;
  logic signed [PW:0] hsum;
  logic in_fire;

  assign gh_p = CW'(GRID_HALF);
  assign gh_n = -gh_p;
  assign mnx = CW'(in_data_i.min_x);
  assign mnz = CW'(in_data_i.min_z);
  assign mxx = CW'(in_data_i.max_x);
  assign mxz = CW'(in_data_i.max_z);
  assign ex  = (in_data_i.req_type == REQ_BOX) ? mxx - CW'(1) : mxx;
  assign ez  = (in_data_i.req_type == REQ_BOX) ? mxz - CW'(1) : mxz;
  // Clip loop bounds to the grid
  assign bxs = (mnx < gh_n) ? gh_n : mnx;
  assign bzs = (mnz < gh_n) ? gh_n : mnz;
  assign bxe = (ex > gh_p) ? gh_p : ex;
  assign bze = (ez > gh_p) ? gh_p : ez;

  always_comb begin
    case (in_data_i.rotation)
      ROT_0:   span = 9'(in_data_i.max_z) - 9'(in_data_i.min_z);
      ROT_90:  span = 9'(in_data_i.max_x) - 9'(in_data_i.min_x);
      ROT_180: span = 9'(in_data_i.min_z) - 9'(in_data_i.max_z);
      default: span = 9'(in_data_i.min_x) - 9'(in_data_i.max_x);
    endcase
  end
  assign span_abs = span[8] ? -span : span;
  assign dy = (HW+1)'(in_data_i.high_y) - (HW+1)'(in_data_i.low_y);
  assign dy_abs = dy[HW] ? -dy : dy;

  // Cell address of the current walk position (or of the read request)
  always_comb begin
    if (state_q == ST_WALK) begin
      ixw = x_q + gh_p;
      izw = z_q + gh_p;
    end else begin
      ixw = mnx + gh_p;
      izw = mnz + gh_p;
    end
  end
  assign ix = ixw[IDX_W-1:0];
  assign iz = izw[IDX_W-1:0];
  assign dt = along_z_q ? z_q - anchor_q : x_q - anchor_q;

  // Divider step and floor/saturate of the quotient
  assign rtry = {rem_q[7:0], num_q[31]};
  assign rge  = rtry >= {1'b0, den_q};
  assign qmag = {1'b0, num_q} + (SW+1)'(neg_q && (rem_q != '0));
  assign qsig = neg_q ? -(SW+2)'(qmag) : (SW+2)'(qmag);

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign load_out    = (state_q == ST_RESP) && (!out_valid_q || out_ready_i);

  // Controller
  always_comb begin
    state_d    = state_q;
    clr_d      = clr_q;
    fill_d     = fill_q;
    clr_resp_d = clr_resp_q;
    req_d      = req_q;
    lo_d       = lo_q;
    hi_d       = hi_q;
    xs_d       = xs_q;
    xe_d       = xe_q;
    zs_d       = zs_q;
    ze_d       = ze_q;
    x_d        = x_q;
    z_d        = z_q;
    anchor_d   = anchor_q;
    along_z_d  = along_z_q;
    slope_d    = slope_q;
    num_d      = num_q;
    den_d      = den_q;
    rem_d      = rem_q;
    cnt_d      = cnt_q;
    neg_d      = neg_q;
    res_d      = res_q;
    v0_d       = 1'b0;
    addr0_d    = addr0_q;
    prod_d     = prod_q;
    case (state_q)
      ST_CLR: begin
        clr_d = clr_q + ADDR_W'(1);
        if (clr_q == ADDR_W'(GRID_CELLS - 1)) begin
          state_d = clr_resp_q ? ST_RESP : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_fire) begin
          req_d   = in_data_i.req_type;
          lo_d    = in_data_i.low_y;
          hi_d    = in_data_i.high_y;
          xs_d    = bxs;
          xe_d    = bxe;
          zs_d    = bzs;
          ze_d    = bze;
          x_d     = bxs;
          z_d     = bzs;
          slope_d = '0;
          res_d   = '0;
          case (in_data_i.req_type)
            REQ_BOX: begin
              state_d = ((bxs <= bxe) && (bzs <= bze)) ? ST_WALK : ST_RESP;
            end
            REQ_RAMP: begin
              along_z_d = (in_data_i.rotation == ROT_0) || (in_data_i.rotation == ROT_180);
              case (in_data_i.rotation)
                ROT_0:   anchor_d = mnz;
                ROT_90:  anchor_d = mnx;
                ROT_180: anchor_d = mxz;
                default: anchor_d = mxx;
              endcase
              if (span == '0) begin
                res_d.status = 1'b1;
                state_d      = ST_RESP;
              end else begin
                num_d   = {dy_abs[HW-1:0], 8'd0};
                den_d   = span_abs[7:0];
                rem_d   = '0;
                cnt_d   = '0;
                neg_d   = (dy[HW] != span[8]) && (dy != '0);
                state_d = ST_DIV;
              end
            end
            REQ_READ: begin
              if ((mnx >= gh_n) && (mnx <= gh_p) && (mnz >= gh_n) && (mnz <= gh_p)) begin
                addr0_d = ADDR_W'(ix) * ADDR_W'(GRID_SIDE) + ADDR_W'(iz);
                state_d = ST_RD1;
              end else begin
                state_d = ST_RESP;
              end
            end
            default: begin
              fill_d     = floor_q;
              clr_d      = '0;
              clr_resp_d = 1'b1;
              state_d    = ST_CLR;
            end
          endcase
        end
      end
      ST_DIV: begin
        rem_d = rge ? rtry - {1'b0, den_q} : rtry;
        num_d = {num_q[30:0], rge};
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          state_d = ST_DFIN;
        end
      end
      ST_DFIN: begin
        // Saturate floored quotient to 32 bits
        if (qsig > (SW+2)'(signed'({1'b0, {(SW-1){1'b1}}}))) begin
          slope_d = {1'b0, {(SW-1){1'b1}}};
        end else if (qsig < -(SW+2)'(signed'({1'b0, 1'b1, {(SW-1){1'b0}}}))) begin
          slope_d = {1'b1, {(SW-1){1'b0}}};
        end else begin
          slope_d = qsig[SW-1:0];
        end
        res_d.slope = slope_d;
        state_d = ((xs_q <= xe_q) && (zs_q <= ze_q)) ? ST_WALK : ST_RESP;
      end
      ST_WALK: begin
        v0_d    = 1'b1;
        prod_d  = PW'(slope_q) * PW'(dt);
        addr0_d = ADDR_W'(ix) * ADDR_W'(GRID_SIDE) + ADDR_W'(iz);
        if (z_q == ze_q) begin
          z_d = zs_q;
          x_d = x_q + CW'(1);
          if (x_q == xe_q) begin
            state_d = ST_DRAIN;
          end
        end else begin
          z_d = z_q + CW'(1);
        end
      end
      ST_DRAIN: begin
        if (!v0_q && !v1_q) begin
          state_d = ST_RESP;
        end
      end
      ST_RD1: begin
        state_d = ST_RD2;
      end
      ST_RD2: begin
        res_d.cell_height = rdata_q;
        state_d           = ST_RESP;
      end
      ST_RESP: begin
        if (load_out) begin
          clr_resp_d = 1'b0;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Target height for the cell in stage 1
  assign hsum = (PW+1)'(prod_q >>> 8) + (PW+1)'(lo_q);
  always_comb begin
    if (req_q == REQ_BOX) begin
      tgt_d = hi_q;
    end else if (hsum > (PW+1)'(signed'({1'b0, {(HW-1){1'b1}}}))) begin
      tgt_d = {1'b0, {(HW-1){1'b1}}};
    end else if (hsum < -(PW+1)'(signed'({1'b0, 1'b1, {(HW-1){1'b0}}}))) begin
      tgt_d = {1'b1, {(HW-1){1'b0}}};
    end else begin
      tgt_d = hsum[HW-1:0];
    end
  end

  // Write port: clearing sweep or max-update from stage 2
  always_comb begin
    if (state_q == ST_CLR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_q;
      mem_wdata = fill_q;
    end else begin
      mem_we    = v1_q && (rdata_q < tgt_q);
      mem_waddr = addr1_q;
      mem_wdata = tgt_q;
    end
  end

  // Memory access
  always_ff @(posedge clk_i) begin
    rdata_q <= height_mem[addr0_q];
    if (mem_we) begin
      height_mem[mem_waddr] <= mem_wdata;
    end
  end

  // Payload and pipeline registers
  always_ff @(posedge clk_i) begin
    req_q     <= req_d;
    lo_q      <= lo_d;
    hi_q      <= hi_d;
    xs_q      <= xs_d;
    xe_q      <= xe_d;
    zs_q      <= zs_d;
    ze_q      <= ze_d;
    x_q       <= x_d;
    z_q       <= z_d;
    anchor_q  <= anchor_d;
    along_z_q <= along_z_d;
    slope_q   <= slope_d;
    num_q     <= num_d;
    den_q     <= den_d;
    rem_q     <= rem_d;
    cnt_q     <= cnt_d;
    neg_q     <= neg_d;
    res_q     <= res_d;
    prod_q    <= prod_d;
    addr0_q   <= addr0_d;
    addr1_q   <= addr0_q;
    tgt_q     <= tgt_d;
    if (load_out) begin
      out_q <= res_q;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLR;
      clr_q       <= '0;
      fill_q      <= '0;
      clr_resp_q  <= 1'b0;
      floor_q     <= '0;
      v0_q        <= 1'b0;
      v1_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      clr_q      <= clr_d;
      fill_q     <= fill_d;
      clr_resp_q <= clr_resp_d;
      v0_q       <= v0_d;
      v1_q       <= v0_q;
      if (cfg_valid_i) begin
        floor_q <= cfg_data_i;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Checks
  a_pipe_in_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v1_q |-> (state_q == ST_WALK || state_q == ST_DRAIN))
    else $error("walk pipeline busy outside walk");
  a_clr_no_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLR) |-> (!v0_q && !v1_q))
    else $error("max-update overlaps clearing sweep");
  a_zero_span: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.status) |-> (out_data_o.slope == '0))
    else $error("zero-span item carries a slope");
  a_div_to_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV && cnt_q == 5'd31) |=> (state_q == ST_DFIN))
    else $error("divider did not finish after 32 steps");

endmodule

>>> tb/heightmap_box_ramp_max_fill_tb.sv
// Testbench for heightmap_box_ramp_max_fill: random and directed grid requests,
// predicted against a behavioral grid model held in a small scoreboard class.
// Depends on hbrmf_pkg and the heightmap_box_ramp_max_fill RTL.
module heightmap_box_ramp_max_fill_tb
  import hbrmf_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  // Grid model and queue of predicted responses
  class grid_scoreboard;
    int heights[GRID_CELLS];
    int floor_h;
    out_t pending[$];
    int errors;
    int ramps, boxes, reads, clears;

    function new();
      floor_h = 0;
      errors = 0;
      foreach (heights[i]) heights[i] = 0;
    endfunction

    function longint fdiv(longint a, longint b);
      longint q;
      q = a / b;
      if ((a % b) != 0 && ((a < 0) != (b < 0))) q--;
      return q;
    endfunction

    function bit on_grid(longint x, longint z);
      return (x + GRID_HALF >= 0) && (x + GRID_HALF < GRID_SIDE) &&
             (z + GRID_HALF >= 0) && (z + GRID_HALF < GRID_SIDE);
    endfunction

    function void raise(longint x, longint z, longint h);
      int idx;
      if (!on_grid(x, z)) return;
      idx = int'((x + GRID_HALF) * GRID_SIDE + (z + GRID_HALF));
      if (heights[idx] < h) heights[idx] = int'(h);
    endfunction

    // Apply one accepted request and queue its response
    function void note_request(in_t r);
      longint mnx, mnz, mxx, mxz, lo, hi, span, anchor, slp, t, h;
      out_t o;
      mnx = r.min_x; mnz = r.min_z; mxx = r.max_x; mxz = r.max_z;
      lo = r.low_y; hi = r.high_y;
      o = '0;
      case (r.req_type)
        REQ_BOX: begin
          boxes++;
          for (longint x = mnx; x < mxx; x++)
            for (longint z = mnz; z < mxz; z++) raise(x, z, hi);
        end
        REQ_RAMP: begin
          ramps++;
          case (r.rotation)
            ROT_0:   begin span = mxz - mnz; anchor = mnz; end
            ROT_90:  begin span = mxx - mnx; anchor = mnx; end
            ROT_180: begin span = mnz - mxz; anchor = mxz; end
            default: begin span = mnx - mxx; anchor = mxx; end
          endcase
          if (span == 0) begin
            o.status = 1'b1;
          end else begin
            slp = fdiv((hi - lo) * 256, span);
            if (slp > 64'sd2147483647) slp = 64'sd2147483647;
            if (slp < -64'sd2147483648) slp = -64'sd2147483648;
            o.slope = slp[31:0];
            for (longint x = mnx; x <= mxx; x++)
              for (longint z = mnz; z <= mxz; z++) begin
                t = (r.rotation == ROT_0 || r.rotation == ROT_180) ? z : x;
                h = lo + fdiv(slp * (t - anchor), 256);
                if (h > 8388607) h = 8388607;
                if (h < -8388608) h = -8388608;
                raise(x, z, h);
              end
          end
        end
        REQ_READ: begin
          reads++;
          if (on_grid(mnx, mnz))
            o.cell_height = heights[(mnx + GRID_HALF) * GRID_SIDE + (mnz + GRID_HALF)];
        end
        default: begin
          clears++;
          foreach (heights[i]) heights[i] = floor_h;
        end
      endcase
      pending.push_back(o);
    endfunction

    // Compare one response with the oldest prediction
    function void check_response(out_t got);
      out_t e;
      if (pending.size() == 0) begin
        $error("unexpected response slope=%0d", got.slope);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.slope !== e.slope) begin
        $error("slope expected %0d actual %0d", e.slope, got.slope); errors++;
      end
      if (got.cell_height !== e.cell_height) begin
        $error("cell_height expected %0d actual %0d", e.cell_height, got.cell_height);
        errors++;
      end
      if (got.status !== e.status) begin
        $error("status expected %0d actual %0d", e.status, got.status); errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  in_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  out_t out_data_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic signed [HW-1:0] cfg_data_i = '0;

  grid_scoreboard sb = new();
  bit quiet_tail = 1'b0;

  heightmap_box_ramp_max_fill i_dut (.*);

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Run limit: covers every item walking the whole grid, plus clears and stalls
  initial begin
    #1000ms;
    $display("end of test: mismatches");
    $finish;
  end

  // Response sink with random stall bursts
  initial begin
    int gap;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) sb.check_response(out_data_o);
      if (!quiet_tail && $urandom_range(0, 5) == 0) begin
        gap = $urandom_range(1, 9);
        out_ready_i <= 1'b0;
        repeat (gap) begin
          @(posedge clk_i);
        end
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Valid stays up between back-to-back items; dropped before idling
  task automatic send_request(in_t r);
    int gap;
    if (!quiet_tail && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 9);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= r;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.note_request(r);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_floor(logic signed [HW-1:0] v);
    wait_drained();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.floor_h = v;
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic signed [7:0] rand_coord();
    int c;
    case ($urandom_range(0, 9))
      0: c = $urandom_range(0, 255) - 128;     // anywhere in the signed 8-bit range, often off grid
      1: c = ($urandom_range(0, 1) ? 64 : -64);
      default: c = int'($urandom_range(0, 40)) - 20;
    endcase
    return c[7:0];
  endfunction

  function automatic in_t make_request(logic [1:0] kind);
    in_t r;
    int w;
    r = '0;
    r.req_type = kind;
    r.rotation = $urandom_range(0, 3);
    r.low_y  = $urandom;
    r.high_y = $urandom;
    if ($urandom_range(0, 2) == 0) begin
      r.low_y  = int'($urandom_range(0, 8000)) - 4000;
      r.high_y = int'($urandom_range(0, 8000)) - 4000;
    end
    r.min_x = rand_coord();
    r.min_z = rand_coord();
    // mostly small boxes, sometimes raw bounds
    if ($urandom_range(0, 5) == 0) begin
      r.max_x = rand_coord();
      r.max_z = rand_coord();
    end else begin
      w = $urandom_range(0, 6); r.max_x = r.min_x + w[7:0];
      w = $urandom_range(0, 6); r.max_z = r.min_z + w[7:0];
    end
    return r;
  endfunction

  function automatic in_t pick(logic [1:0] k, int mnx, int mnz, int mxx, int mxz,
                               int lo, int hi, logic [1:0] rot);
    in_t r;
    r.req_type = k; r.min_x = mnx[7:0]; r.min_z = mnz[7:0];
    r.max_x = mxx[7:0]; r.max_z = mxz[7:0];
    r.low_y = lo[23:0]; r.high_y = hi[23:0]; r.rotation = rot;
    return r;
  endfunction

  initial begin
    in_t r;
    logic [1:0] kind;
    int n;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: extremes, every request, every rotation, zero span, saturation
    send_request(pick(REQ_READ, 0, 0, 0, 0, 0, 0, ROT_0));
    send_request(pick(REQ_BOX, -64, -64, -60, -60, 0, 8388607, ROT_0));
    send_request(pick(REQ_READ, -64, -64, 0, 0, 0, 0, ROT_0));
    send_request(pick(REQ_BOX, 60, 60, 64, 64, 0, -8388608, ROT_0));
    send_request(pick(REQ_BOX, 62, 62, 66, 66, 0, 500, ROT_0));
    send_request(pick(REQ_READ, 64, 64, 0, 0, 0, 0, ROT_0));
    send_request(pick(REQ_READ, 65, -128, 0, 0, 0, 0, ROT_0));
    send_request(pick(REQ_RAMP, 0, 0, 3, 4, 0, 1024, ROT_0));
    send_request(pick(REQ_RAMP, 0, 0, 4, 3, 0, 1024, ROT_90));
    send_request(pick(REQ_RAMP, 0, 0, 3, 4, 1024, -7, ROT_180));
    send_request(pick(REQ_RAMP, 0, 0, 4, 3, -1000, 777, ROT_270));
    send_request(pick(REQ_RAMP, 5, 5, 8, 5, 0, 100, ROT_0));
    send_request(pick(REQ_RAMP, 5, 5, 5, 8, 0, 100, ROT_270));
    send_request(pick(REQ_RAMP, 10, 10, 11, 11, -8388608, 8388607, ROT_0));
    send_request(pick(REQ_RAMP, 10, 10, 11, 11, 8388607, -8388608, ROT_90));
    send_request(pick(REQ_RAMP, 20, 20, 18, 23, 0, 300, ROT_0));
    send_request(pick(REQ_BOX, 30, 30, 27, 33, 0, 300, ROT_0));
    send_request(pick(REQ_READ, 3, 4, 0, 0, 0, 0, ROT_0));
    send_request(pick(REQ_READ, 10, 11, 0, 0, 0, 0, ROT_0));
    write_floor(24'sh7FFFFF);
    send_request(pick(REQ_CLEAR, 0, 0, 0, 0, 0, 0, ROT_0));
    send_request(pick(REQ_READ, -3, 7, 0, 0, 0, 0, ROT_0));
    write_floor(24'sh800000);
    send_request(pick(REQ_CLEAR, 0, 0, 0, 0, 0, 0, ROT_0));
    send_request(pick(REQ_READ, 12, -9, 0, 0, 0, 0, ROT_0));

    // Random phases; floor changes between phases, sender pauses to drain
    for (int ph = 0; ph < 8; ph++) begin
      write_floor(ph == 7 ? 24'sd0 : 24'($urandom));
      if (ph == 7) quiet_tail = 1'b1;
      for (n = 0; n < 50; n++) begin
        case ($urandom_range(0, 19))
          0: kind = REQ_CLEAR;
          1, 2, 3, 4, 5, 6: kind = REQ_READ;
          7, 8, 9, 10, 11, 12: kind = REQ_RAMP;
          default: kind = REQ_BOX;
        endcase
        r = make_request(kind);
        send_request(r);
      end
    end

    wait_drained();
    repeat (40) @(posedge clk_i);
    $display("covered %0d boxes, %0d ramps, %0d reads, %0d clears",
             sb.boxes, sb.ramps, sb.reads, sb.clears);
    $display("with random handshake stalls and several floor heights");
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

>>> sim.f
sv/hbrmf_pkg.sv
sv/heightmap_box_ramp_max_fill.sv
tb/heightmap_box_ramp_max_fill_tb.sv
